// ===== src/thread_context_scheduler_unit_defines.svh =====
// Assertion macros used by the thread context scheduler engine (tcs_engine).
`ifndef THREAD_CONTEXT_SCHEDULER_UNIT_DEFINES_SVH
`define THREAD_CONTEXT_SCHEDULER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TCS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcs assertion failed");
`define TCS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcs assertion failed");
`else
`define TCS_ASSERT_IMPL(name, ante, cons)
`define TCS_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== src/tcs_pkg.sv =====
// Types and constants of the thread context scheduler.
package tcs_pkg;

  localparam int SP_W  = 8;
  localparam int ID_W  = 2;
  localparam int OP_W  = 3;

  localparam logic [SP_W-1:0] BASE_RST    = 8'h3F;
  localparam logic [SP_W-1:0] STRIDE_RST  = 8'h10;
  localparam logic [SP_W-1:0] FRAME_WORDS = 8'd7;

  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_STRIDE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_YIELD  = 3'd1,
    OP_CREATE = 3'd2,
    OP_EXIT   = 3'd3,
    OP_BOOT   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SAVE,
    S_SCAN,
    S_FOUND,
    S_PRESET,
    S_PLACE,
    S_MISS
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [SP_W-1:0] sp;
    status_t         status;
  } result_t;

  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] op;
    logic [SP_W-1:0] sp;
    logic            res_ready;
  } ctl_t;

  typedef struct packed {
    logic    idle;
    logic    done;
    result_t res;
  } resp_t;

endpackage

// ===== src/tcs_engine.sv =====
// Scheduler sequencer: slot table, one-slot-per-cycle stepper and shared preset adder.
`include "thread_context_scheduler_unit_defines.svh"

module tcs_engine #(
  parameter int THREAD_SLOTS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcs_pkg::ctl_t                 ctl,
  input  logic [tcs_pkg::SP_W-1:0]      stack_base,
  input  logic [tcs_pkg::SP_W-1:0]      stack_stride,
  output tcs_pkg::resp_t                rsp
);

  localparam int SLOT_W = (THREAD_SLOTS > 2) ? $clog2(THREAD_SLOTS) : 1;
  localparam int CNT_W  = $clog2(2 * THREAD_SLOTS);
  localparam logic [SLOT_W-1:0] TOP_SLOT = SLOT_W'(THREAD_SLOTS - 1);
  localparam logic [CNT_W-1:0]  LAST_PP  = CNT_W'(2 * THREAD_SLOTS - 1);
  localparam logic [CNT_W-1:0]  LAST_RR  = CNT_W'(THREAD_SLOTS - 1);

  tcs_pkg::state_t state_r, state_nxt;

  logic [THREAD_SLOTS-1:0]  occ_r, occ_nxt;
  logic [SLOT_W-1:0]        cur_r, cur_nxt;
  logic                     cur_vld_r, cur_vld_nxt;
  logic                     up_r, up_nxt;
  logic [tcs_pkg::OP_W-1:0] op_r, op_nxt;
  logic [tcs_pkg::SP_W-1:0] sp_r, sp_nxt;
  logic [SLOT_W-1:0]        s_r, s_nxt;
  logic                     sup_r, sup_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [tcs_pkg::SP_W-1:0] acc_r, acc_nxt;

  logic [tcs_pkg::SP_W-1:0] stk_r [THREAD_SLOTS];
  logic                     stk_we;
  logic [SLOT_W-1:0]        stk_addr;
  logic [tcs_pkg::SP_W-1:0] stk_wdata;

  logic                     in_op_ok;
  logic                     is_tick, is_yield, is_exit, is_place, is_boot;
  logic [SLOT_W-1:0]        step_s;
  logic                     step_up;
  logic                     step_hit;
  logic [CNT_W-1:0]         scan_last;
  logic [tcs_pkg::SP_W-1:0] add_sum;

  always_comb begin
    unique case (ctl.op)
      tcs_pkg::OP_TICK,
      tcs_pkg::OP_YIELD,
      tcs_pkg::OP_CREATE,
      tcs_pkg::OP_EXIT,
      tcs_pkg::OP_BOOT: in_op_ok = 1'b1;
      default:          in_op_ok = 1'b0;
    endcase
  end

  assign is_tick  = (op_r == tcs_pkg::OP_TICK);
  assign is_yield = (op_r == tcs_pkg::OP_YIELD);
  assign is_exit  = (op_r == tcs_pkg::OP_EXIT);
  assign is_boot  = (op_r == tcs_pkg::OP_BOOT);
  assign is_place = (op_r == tcs_pkg::OP_CREATE) || is_boot;

  // slot stepper: ping-pong for tick, wrap-up otherwise
  always_comb begin
    step_s  = s_r;
    step_up = sup_r;
    if (is_tick) begin
      if (sup_r) begin
        if (s_r == TOP_SLOT) begin
          step_up = 1'b0;
          step_s  = s_r - 1'b1;
        end else begin
          step_s  = s_r + 1'b1;
        end
      end else begin
        if (s_r == '0) begin
          step_up = 1'b1;
          step_s  = SLOT_W'(1);
        end else begin
          step_s  = s_r - 1'b1;
        end
      end
    end else begin
      step_s = (s_r == TOP_SLOT) ? '0 : s_r + 1'b1;
    end
    step_hit = is_place ? !occ_r[step_s] : occ_r[step_s];
  end

  assign scan_last = is_tick ? LAST_PP : LAST_RR;
  assign add_sum   = acc_r + ((cnt_r == '0) ? tcs_pkg::FRAME_WORDS : stack_stride);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcs_pkg::S_IDLE:   if (ctl.start && in_op_ok) state_nxt = tcs_pkg::S_SAVE;
      tcs_pkg::S_SAVE:   state_nxt = tcs_pkg::S_SCAN;
      tcs_pkg::S_SCAN: begin
        if (step_hit) begin
          state_nxt = is_place ? tcs_pkg::S_PRESET : tcs_pkg::S_FOUND;
        end else if (cnt_r == scan_last) begin
          state_nxt = tcs_pkg::S_MISS;
        end
      end
      tcs_pkg::S_PRESET: if (cnt_r == '0) state_nxt = tcs_pkg::S_PLACE;
      tcs_pkg::S_FOUND,
      tcs_pkg::S_PLACE,
      tcs_pkg::S_MISS:   if (ctl.res_ready) state_nxt = tcs_pkg::S_IDLE;
      default:           state_nxt = tcs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    occ_nxt     = occ_r;
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    up_nxt      = up_r;
    op_nxt      = op_r;
    sp_nxt      = sp_r;
    s_nxt       = s_r;
    sup_nxt     = sup_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    stk_we      = 1'b0;
    stk_addr    = cur_r;
    stk_wdata   = sp_r;
    rsp.idle    = (state_r == tcs_pkg::S_IDLE);
    rsp.done    = 1'b0;
    rsp.res     = '{id: '0, sp: '0, status: tcs_pkg::ST_OK};
    unique case (state_r)
      tcs_pkg::S_IDLE: begin
        if (ctl.start) begin
          op_nxt  = ctl.op;
          sp_nxt  = ctl.sp;
          cnt_nxt = '0;
          sup_nxt = up_r;
          if (ctl.op == tcs_pkg::OP_TICK || ctl.op == tcs_pkg::OP_YIELD) begin
            s_nxt = cur_r;
          end else begin
            s_nxt = TOP_SLOT;
          end
          if (ctl.op == tcs_pkg::OP_BOOT) begin
            occ_nxt = '0;
            up_nxt  = 1'b1;
            sup_nxt = 1'b1;
          end
        end
      end
      tcs_pkg::S_SAVE: begin
        if (cur_vld_r && (is_tick || is_yield)) stk_we = 1'b1;
        if (cur_vld_r && is_exit) occ_nxt[cur_r] = 1'b0;
      end
      tcs_pkg::S_SCAN: begin
        s_nxt   = step_s;
        sup_nxt = step_up;
        cnt_nxt = cnt_r + 1'b1;
        if (step_hit && is_place) begin
          acc_nxt = stack_base;
          cnt_nxt = CNT_W'(step_s);
        end
      end
      tcs_pkg::S_PRESET: begin
        acc_nxt = add_sum;
        if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
      end
      tcs_pkg::S_PLACE: begin
        rsp.res = '{id: tcs_pkg::ID_W'(s_r), sp: acc_r, status: tcs_pkg::ST_OK};
        if (ctl.res_ready) begin
          rsp.done     = 1'b1;
          stk_we       = 1'b1;
          stk_addr     = s_r;
          stk_wdata    = acc_r;
          occ_nxt[s_r] = 1'b1;
          if (is_boot) begin
            cur_nxt     = s_r;
            cur_vld_nxt = 1'b1;
          end
        end
      end
      tcs_pkg::S_FOUND: begin
        rsp.res = '{id: tcs_pkg::ID_W'(s_r), sp: stk_r[s_r], status: tcs_pkg::ST_OK};
        if (ctl.res_ready) begin
          rsp.done    = 1'b1;
          cur_nxt     = s_r;
          cur_vld_nxt = 1'b1;
          if (is_tick) up_nxt = sup_r;
        end
      end
      tcs_pkg::S_MISS: begin
        rsp.res = '{id: '0, sp: '0,
                    status: is_place ? tcs_pkg::ST_FULL : tcs_pkg::ST_EMPTY};
        if (ctl.res_ready) begin
          rsp.done = 1'b1;
          if (!is_place) cur_vld_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tcs_pkg::S_IDLE;
      occ_r     <= '0;
      cur_r     <= '0;
      cur_vld_r <= 1'b0;
      up_r      <= 1'b1;
      op_r      <= tcs_pkg::OP_TICK;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      occ_r     <= occ_nxt;
      cur_r     <= cur_nxt;
      cur_vld_r <= cur_vld_nxt;
      up_r      <= up_nxt;
      op_r      <= op_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sp_r  <= sp_nxt;
    s_r   <= s_nxt;
    sup_r <= sup_nxt;
    acc_r <= acc_nxt;
    if (stk_we) stk_r[stk_addr] <= stk_wdata;
  end

  `TCS_ASSERT_IMPL(a_start_only_idle, ctl.start, rsp.idle)
  `TCS_ASSERT_IMPL(a_done_has_room, rsp.done, ctl.res_ready)
  `TCS_ASSERT_IMPL(a_current_occupied, rsp.idle && cur_vld_r, occ_r[cur_r])
  `TCS_ASSERT_IMPL(a_place_slot_free, state_r == tcs_pkg::S_PLACE, !occ_r[s_r])
  `TCS_ASSERT_NEXT(a_hit_leaves_scan, (state_r == tcs_pkg::S_SCAN) && step_hit,
                   (state_r == tcs_pkg::S_FOUND) || (state_r == tcs_pkg::S_PRESET))

endmodule

// ===== src/thread_context_scheduler_unit.sv =====
// Top level of the thread context scheduler: stream ports, APB registers, result register.
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    tuser operation, tdata stack_pointer
//  out_     out  out_tvalid/out_tready  tdata thread_id, restore_sp; tuser status
//  cfg_     in   APB, pready tied high  0x0 stack_base, 0x4 stack_stride
//
// An item passes through save and then the scan: the slot stepper tests one slot a cycle, at most
// 2*THREAD_SLOTS steps for tick and THREAD_SLOTS for the others; create and boot then add to stack_base
// slot number times stack_stride and FRAME_WORDS in the shared preset adder. in_tready is low while busy.
// A finished item waits in the result register; the next item is accepted meanwhile.
// Reset is synchronous; slot stack values are undefined until a slot is created.

module thread_context_scheduler_unit #(
  parameter int THREAD_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] stack_pointer
  input  logic [2:0]  in_tuser,   // [2:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] thread_id, [9:2] restore_sp, zero above
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [tcs_pkg::SP_W-1:0] base_r, stride_r;
  logic                     cfg_wr;
  logic                     out_vld_r;
  tcs_pkg::result_t         out_res_r;
  tcs_pkg::ctl_t            ctl;
  tcs_pkg::resp_t           rsp;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == tcs_pkg::REG_STRIDE) ? {24'd0, stride_r}
                                                            : {24'd0, base_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= tcs_pkg::BASE_RST;
      stride_r <= tcs_pkg::STRIDE_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == tcs_pkg::REG_BASE) base_r <= cfg_pwdata[7:0];
      else                                   stride_r <= cfg_pwdata[7:0];
    end
  end

  assign in_tready     = rsp.idle;
  assign ctl.start     = in_tvalid && in_tready;
  assign ctl.op        = in_tuser;
  assign ctl.sp        = in_tdata;
  assign ctl.res_ready = !out_vld_r || out_tready;

  tcs_engine #(
    .THREAD_SLOTS(THREAD_SLOTS)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .stack_base   (base_r),
    .stack_stride (stride_r),
    .rsp          (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rsp.done) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.done) out_res_r <= rsp.res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_res_r.sp, out_res_r.id};
  assign out_tuser  = out_res_r.status;

endmodule
